// ===== rtl/refcounted_slot_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Clocked, reset-qualified property wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define RSAU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rsau_pkg.sv =====
// ----------------------------------------------------------------------------
// rsau_pkg
// Shared constants and codes of the slot allocator.
// ----------------------------------------------------------------------------
package rsau_pkg;

   localparam int SLOTS    = 32;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_W  = 16;
   localparam int HANDLE_W = 9;
   localparam int BASE_W   = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_INC    = 2'd1,
      ACT_DEC    = 2'd2,
      ACT_LOOKUP = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BAD      = 3'd2,
      ST_NOT_OPEN = 3'd3,
      ST_SAT      = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

// ===== rtl/rsau_req_if.sv =====
// ----------------------------------------------------------------------------
// rsau_req_if
// Request channel: valid/ready with action and handle.
// ----------------------------------------------------------------------------
interface rsau_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [rsau_pkg::HANDLE_W-1:0] handle;

   modport source (output valid, action, handle, input ready);
   modport sink   (input valid, action, handle, output ready);
endinterface

// ===== rtl/rsau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rsau_rsp_if
// Response channel: valid/ready with handle, status, released and count.
// ----------------------------------------------------------------------------
interface rsau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rsau_pkg::HANDLE_W-1:0] result_handle;
   logic [2:0]                    status;
   logic                          released;
   logic [rsau_pkg::COUNT_W-1:0]  count_after;

   modport source (output valid, result_handle, status, released, count_after,
                   input ready);
   modport sink   (input valid, result_handle, status, released, count_after,
                   output ready);
endinterface

// ===== rtl/rsau_ram.sv =====
// ----------------------------------------------------------------------------
// rsau_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsau_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/refcounted_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_unit
// Reference-counted handle allocator over a table of slot counts.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one operation per transfer: allocate, increment,
//    decrement or lookup, with a handle (ignored on allocate).
//  - rsp_ch returns exactly one result per request transfer, in order.
//  - csr_we/csr_wdata load handle_base; write only while the block is idle.
//  - Each request passes an accept step, in which the idle state issues the
//    count read, and an execute step that modifies and writes back the count
//    and loads the response register. The result is valid the cycle after that.
//  - A new request is not accepted until the current one leaves its execute
//    step, as the count RAM sees a single read-modify-write per request.
//  - A result that waits in the response register does not block the next
//    accept; the block holds in its execute step only if that register is
//    still occupied, and resumes the cycle rsp_ch.ready takes it.
//  - Reset (synchronous, active high) clears the per-slot busy bits, so all
//    counts read as zero immediately; no clearing pass is needed. It also
//    clears handle_base and drops rsp_ch.valid.
// ----------------------------------------------------------------------------
`include "refcounted_slot_allocator_unit_assert.svh"

module refcounted_slot_allocator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [rsau_pkg::BASE_W-1:0] csr_wdata,
   rsau_req_if.sink                    req_ch,
   rsau_rsp_if.source                  rsp_ch
);

   localparam int SW = rsau_pkg::SLOT_W;
   localparam int HW = rsau_pkg::HANDLE_W;
   localparam int CW = rsau_pkg::COUNT_W;
   localparam int BW = rsau_pkg::BASE_W;

   // control state
   rsau_pkg::state_type  state_ff, state_in;
   logic [BW-1:0]        base_ff;
   logic [rsau_pkg::SLOTS-1:0] busy_ff;   // count != 0; doubles as valid bit
   logic                 rsp_valid_ff;

   // captured request
   rsau_pkg::action_type act_ff;
   logic [HW-1:0]        handle_ff;
   logic [SW-1:0]        slot_ff;
   logic                 bad_ff;
   logic                 full_ff;

   // response payload
   logic [HW-1:0]        rsp_handle_ff;
   rsau_pkg::status_type rsp_status_ff;
   logic                 rsp_rel_ff;
   logic [CW-1:0]        rsp_cnt_ff;

   logic                 req_fire;
   logic                 exec_go;
   logic                 idle_ready;

   // lowest free slot
   logic [SW-1:0]        free_slot;
   logic                 table_full;

   // handle decode
   logic [HW:0]          diff;
   logic                 req_bad;
   logic [SW-1:0]        req_slot;
   logic [HW-1:0]        grant_handle;
   rsau_pkg::action_type req_act;

   // RAM
   logic [CW-1:0]        ram_rdata;
   logic                 ram_we;
   logic [CW-1:0]        new_cnt;

   // execute results
   logic [CW-1:0]        cur_cnt;
   logic                 wr_need;
   logic [HW-1:0]        res_handle;
   rsau_pkg::status_type res_status;
   logic                 res_rel;
   logic [CW-1:0]        res_cnt;

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   always_comb begin
      free_slot = '0;
      for (int i = rsau_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   assign table_full   = &busy_ff;
   assign req_act      = rsau_pkg::action_type'(req_ch.action);
   assign diff         = {1'b0, req_ch.handle} - {(HW + 1 - BW)'(0), base_ff};
   // out of range below the base (borrow) or at base + SLOTS and above
   assign req_bad      = diff[HW] || (diff[HW-1:0] >= HW'(rsau_pkg::SLOTS));
   assign req_slot     = (req_act == rsau_pkg::ACT_ALLOC) ? free_slot : diff[SW-1:0];
   assign grant_handle = {(HW - BW)'(0), base_ff} + HW'(free_slot);

   assign req_fire = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------
   // State machine
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsau_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = rsau_pkg::S_EXEC;
            end
         end
         rsau_pkg::S_EXEC: begin
            if (exec_go) begin
               state_in = rsau_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rsau_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      idle_ready = 1'b0;
      exec_go    = 1'b0;
      case (state_ff)
         rsau_pkg::S_IDLE: begin
            idle_ready = 1'b1;
         end
         rsau_pkg::S_EXEC: begin
            // finish once the response register is free or draining
            exec_go = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            idle_ready = 1'b0;
            exec_go    = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = idle_ready;

   // ------------------------------------------------------------------
   // Count RAM: read on accept, write back on execute
   // ------------------------------------------------------------------
   rsau_ram #(
      .WIDTH (CW),
      .DEPTH (rsau_pkg::SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (new_cnt),
      .rd_en   (req_fire),
      .rd_addr (req_slot),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Modify step
   // ------------------------------------------------------------------
   // a slot with a clear busy bit holds count zero, whatever the RAM says
   assign cur_cnt = busy_ff[slot_ff] ? ram_rdata : '0;

   always_comb begin
      wr_need    = 1'b0;
      new_cnt    = cur_cnt;
      res_handle = handle_ff;
      res_status = rsau_pkg::ST_OK;
      res_rel    = 1'b0;
      res_cnt    = cur_cnt;
      if (act_ff == rsau_pkg::ACT_ALLOC) begin
         if (full_ff) begin
            res_handle = '0;
            res_status = rsau_pkg::ST_FULL;
            res_cnt    = '0;
         end else begin
            wr_need = 1'b1;
            new_cnt = CW'(1);
            res_cnt = CW'(1);
         end
      end else if (bad_ff) begin
         res_status = rsau_pkg::ST_BAD;
         res_cnt    = '0;
      end else begin
         case (act_ff)
            rsau_pkg::ACT_INC: begin
               if (cur_cnt == rsau_pkg::COUNT_MAX) begin
                  res_status = rsau_pkg::ST_SAT;
               end else begin
                  wr_need = 1'b1;
                  new_cnt = cur_cnt + CW'(1);
                  res_cnt = new_cnt;
               end
            end
            rsau_pkg::ACT_DEC: begin
               if (cur_cnt == '0) begin
                  res_status = rsau_pkg::ST_NOT_OPEN;
               end else begin
                  wr_need = 1'b1;
                  new_cnt = cur_cnt - CW'(1);
                  res_cnt = new_cnt;
                  res_rel = (new_cnt == '0);
               end
            end
            rsau_pkg::ACT_LOOKUP: begin
               if (cur_cnt == '0) begin
                  res_status = rsau_pkg::ST_NOT_OPEN;
               end
            end
            default: begin
               res_status = rsau_pkg::ST_OK;
            end
         endcase
      end
   end

   assign ram_we = exec_go && wr_need;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsau_pkg::S_IDLE;
         base_ff      <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (ram_we) begin
            busy_ff[slot_ff] <= (new_cnt != '0);
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff    <= req_act;
         handle_ff <= (req_act == rsau_pkg::ACT_ALLOC) ? grant_handle : req_ch.handle;
         slot_ff   <= req_slot;
         bad_ff    <= req_bad;
         full_ff   <= table_full;
      end
      if (exec_go) begin
         rsp_handle_ff <= res_handle;
         rsp_status_ff <= res_status;
         rsp_rel_ff    <= res_rel;
         rsp_cnt_ff    <= res_cnt;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.released      = rsp_rel_ff;
   assign rsp_ch.count_after   = rsp_cnt_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `RSAU_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_fire,
      state_ff == rsau_pkg::S_EXEC, "accepted request did not enter execute")
   `RSAU_ASSERT_SAME(a_rsp_after_exec, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == rsau_pkg::S_EXEC), "response raised without execute step")
   `RSAU_ASSERT_NEXT(a_zero_frees_slot, clock, reset, ram_we && (new_cnt == '0),
      !busy_ff[$past(slot_ff)], "count written to zero left slot busy")
   `RSAU_ASSERT_SAME(a_grant_free_slot, clock, reset,
      exec_go && (act_ff == rsau_pkg::ACT_ALLOC) && !full_ff,
      !busy_ff[slot_ff], "allocate granted a busy slot")

endmodule
